### rtl/assert_macros.svh
// Assertion helpers, clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

### rtl/art_pkg.sv
package art_pkg;

    localparam int DEFAULT_SLOTS   = 4;
    localparam int DATA_W          = 64;
    localparam int INTERVAL_W      = 24;
    localparam int ATTEMPT_W       = 3;
    localparam int SLOT_W          = 2;
    localparam int STATUS_W        = 3;
    localparam int OP_W            = 2;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 24'd400000;
    localparam logic [ATTEMPT_W-1:0]  MAX_ATT_RESET  = 3'd6;

    typedef enum logic [OP_W-1:0] {
        OP_SUBMIT = 2'd0,
        OP_ACK    = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_HELD      = 3'd0,
        STAT_FULL      = 3'd1,
        STAT_ACKED     = 3'd2,
        STAT_UNMATCHED = 3'd3,
        STAT_RETX      = 3'd4,
        STAT_GIVEUP    = 3'd5,
        STAT_IDLE      = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_WRITE
    } state_t;

    // Register indexes on the configuration port.
    typedef enum logic {
        REG_INTERVAL = 1'b0,
        REG_MAX_ATT  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [DATA_W-1:0]    device;
        logic [DATA_W-1:0]    tag;
        logic [ATTEMPT_W-1:0] attempts;
        logic [DATA_W-1:0]    due;
    } entry_t;

endpackage

### rtl/ack_retransmit_tracker_unit.sv
// Channel   | Direction | Contents
// s_axis    | in        | tuser: op; tdata: node_id, command_tag, now_us
// m_axis    | out       | tuser: status; tdata: slot, out_node_id, out_command_tag,
//           |           |        attempt_count
// apb       | in/out    | reg 0 retry_interval_us at 0x0, reg 1 max_attempts at 0x4
//
// An item is accepted in S_IDLE, then each slot scanned takes a memory read (S_READ)
// and a compare on the shared 65-bit adder (S_CHECK), plus a write (S_WRITE) when a
// slot is claimed or retransmitted.
// Reset clears the valid bits and loads the register defaults; no clearing pass.
// A stalled m_axis holds the sequencer at its final step until the result is taken.
`include "assert_macros.svh"

module ack_retransmit_tracker_unit #(
    parameter int SLOTS = art_pkg::DEFAULT_SLOTS
) (
    input  logic         clk,
    input  logic         rst_n,
    // s_tdata, low bit up: node_id[63:0], command_tag[127:64], now_us[191:128]
    input  logic [191:0] s_tdata,
    // s_tuser: op[1:0]
    input  logic [1:0]   s_tuser,
    input  logic         s_tvalid,
    output logic         s_tready,
    // m_tdata, low bit up: slot[1:0], out_node_id[65:2], out_command_tag[129:66],
    // attempt_count[132:130], zero fill[135:133]
    output logic [135:0] m_tdata,
    // m_tuser: status[2:0]
    output logic [2:0]   m_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int DW    = art_pkg::DATA_W;
    localparam int AW    = art_pkg::ATTEMPT_W;

    // Configuration registers
    logic [art_pkg::INTERVAL_W-1:0] interval_reg;
    logic [AW-1:0]                  max_att_reg;
    logic                           cfg_write;
    art_pkg::reg_idx_t              cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = art_pkg::reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg <= art_pkg::INTERVAL_RESET;
            max_att_reg  <= art_pkg::MAX_ATT_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                art_pkg::REG_INTERVAL: interval_reg <= pwdata[art_pkg::INTERVAL_W-1:0];
                art_pkg::REG_MAX_ATT:  max_att_reg  <= pwdata[AW-1:0];
                default:               interval_reg <= interval_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            art_pkg::REG_INTERVAL: prdata = {{(32-art_pkg::INTERVAL_W){1'b0}}, interval_reg};
            art_pkg::REG_MAX_ATT:  prdata = {{(32-AW){1'b0}}, max_att_reg};
            default:               prdata = '0;
        endcase
    end

    // Sequencer state
    art_pkg::state_t   state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [SLOTS-1:0]  valid_reg, valid_next;

    // Request held while it is worked on
    art_pkg::op_t      op_reg;
    logic [DW-1:0]     dev_reg;
    logic [DW-1:0]     tag_reg;
    logic [DW-1:0]     now_reg;

    // Slot memory
    art_pkg::entry_t   mem [SLOTS];
    art_pkg::entry_t   rd_reg;
    logic              mem_we;
    art_pkg::entry_t   mem_wdata;

    // Result register
    logic                       out_valid_reg;
    art_pkg::status_t           out_status_reg;
    logic [art_pkg::SLOT_W-1:0] out_slot_reg;
    logic [DW-1:0]              out_dev_reg;
    logic [DW-1:0]              out_tag_reg;
    logic [AW-1:0]              out_att_reg;

    logic                       load_out;
    art_pkg::status_t           res_status;
    logic [DW-1:0]              res_dev;
    logic [DW-1:0]              res_tag;
    logic [AW-1:0]              res_att;
    logic                       res_slot_en;

    logic                       out_free;
    logic                       accept;
    logic                       last_slot;
    logic                       slot_vld;
    logic                       key_match;

    // Shared adder: now - due for the due check, now + interval for a new due time
    logic [DW-1:0]              add_b;
    logic                       add_cin;
    logic [DW:0]                add_sum;
    logic                       due_reached;

    assign s_tready  = (state_reg == art_pkg::S_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign last_slot = (idx_reg == IDX_W'(SLOTS - 1));
    assign slot_vld  = valid_reg[idx_reg];
    assign key_match = (rd_reg.device == dev_reg) && (rd_reg.tag == tag_reg);

    always_comb
    begin
        if (state_reg == art_pkg::S_WRITE)
        begin
            add_b   = {{(DW-art_pkg::INTERVAL_W){1'b0}}, interval_reg};
            add_cin = 1'b0;
        end
        else
        begin
            add_b   = ~rd_reg.due;
            add_cin = 1'b1;
        end
    end

    assign add_sum     = {1'b0, now_reg} + {1'b0, add_b} + {{DW{1'b0}}, add_cin};
    assign due_reached = add_sum[DW];

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        valid_next  = valid_reg;
        mem_we      = 1'b0;
        mem_wdata   = rd_reg;
        load_out    = 1'b0;
        res_status  = art_pkg::STAT_IDLE;
        res_dev     = '0;
        res_tag     = '0;
        res_att     = '0;
        res_slot_en = 1'b0;

        unique case (state_reg)
            art_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    idx_next   = '0;
                    state_next = art_pkg::S_READ;
                end
            end

            art_pkg::S_READ:
            begin
                state_next = art_pkg::S_CHECK;
            end

            art_pkg::S_CHECK:
            begin
                priority if (op_reg == art_pkg::OP_SUBMIT && !slot_vld)
                begin
                    state_next = art_pkg::S_WRITE;
                end
                else if (op_reg == art_pkg::OP_ACK && slot_vld && key_match)
                begin
                    res_status  = art_pkg::STAT_ACKED;
                    res_att     = rd_reg.attempts;
                    res_slot_en = 1'b1;
                    if (out_free)
                    begin
                        load_out            = 1'b1;
                        valid_next[idx_reg] = 1'b0;
                        state_next          = art_pkg::S_IDLE;
                    end
                end
                else if (op_reg == art_pkg::OP_TICK && slot_vld && due_reached)
                begin
                    if (rd_reg.attempts >= max_att_reg)
                    begin
                        // Limit reached: free the slot
                        res_status  = art_pkg::STAT_GIVEUP;
                        res_dev     = rd_reg.device;
                        res_tag     = rd_reg.tag;
                        res_att     = rd_reg.attempts;
                        res_slot_en = 1'b1;
                        if (out_free)
                        begin
                            load_out            = 1'b1;
                            valid_next[idx_reg] = 1'b0;
                            state_next          = art_pkg::S_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = art_pkg::S_WRITE;
                    end
                end
                else if (last_slot || op_reg == art_pkg::OP_NONE)
                begin
                    priority if (op_reg == art_pkg::OP_SUBMIT)
                        res_status = art_pkg::STAT_FULL;
                    else if (op_reg == art_pkg::OP_ACK)
                        res_status = art_pkg::STAT_UNMATCHED;
                    else
                        res_status = art_pkg::STAT_IDLE;
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        state_next = art_pkg::S_IDLE;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = art_pkg::S_READ;
                end
            end

            art_pkg::S_WRITE:
            begin
                res_slot_en  = 1'b1;
                mem_wdata.due = add_sum[DW-1:0];
                if (op_reg == art_pkg::OP_SUBMIT)
                begin
                    mem_wdata.device   = dev_reg;
                    mem_wdata.tag      = tag_reg;
                    mem_wdata.attempts = AW'(1);
                    res_status         = art_pkg::STAT_HELD;
                    res_att            = AW'(1);
                end
                else
                begin
                    mem_wdata.attempts = rd_reg.attempts + AW'(1);
                    res_status         = art_pkg::STAT_RETX;
                    res_dev            = rd_reg.device;
                    res_tag            = rd_reg.tag;
                    res_att            = rd_reg.attempts + AW'(1);
                end
                if (out_free)
                begin
                    mem_we              = 1'b1;
                    load_out            = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    state_next          = art_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = art_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= art_pkg::S_IDLE;
            idx_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= art_pkg::op_t'(s_tuser);
            dev_reg <= s_tdata[DW-1:0];
            tag_reg <= s_tdata[2*DW-1:DW];
            now_reg <= s_tdata[3*DW-1:2*DW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[idx_reg] <= mem_wdata;
        end
        rd_reg <= mem[idx_reg];
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_status_reg <= res_status;
            out_slot_reg   <= res_slot_en ? art_pkg::SLOT_W'(idx_reg) : '0;
            out_dev_reg    <= res_dev;
            out_tag_reg    <= res_tag;
            out_att_reg    <= res_att;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_att_reg, out_tag_reg, out_dev_reg, out_slot_reg};

    `ASSERT_NEXT(a_accept_starts_scan, accept, state_reg == art_pkg::S_READ)
    `ASSERT_NEXT(a_valid_steady_on_read, state_reg == art_pkg::S_READ,
                 valid_reg == $past(valid_reg))
    `ASSERT_NOW(a_held_first_attempt,
                out_valid_reg && out_status_reg == art_pkg::STAT_HELD,
                out_att_reg == AW'(1))
    `ASSERT_NOW(a_result_only_on_finish, load_out,
                out_free && (state_reg == art_pkg::S_CHECK || state_reg == art_pkg::S_WRITE))

endmodule
